// ----- hdl/range_sample_conditioner_defines.svh -----
// Assertion macros for the range sample conditioner checker.
// Used by rsc_checker.sv; no other dependencies.
`ifndef RANGE_SAMPLE_CONDITIONER_DEFINES_SVH
`define RANGE_SAMPLE_CONDITIONER_DEFINES_SVH

// Generic clocked assertion, disabled while reset is low.
`define RSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same, bound to the block's own clock and reset names.
`define RSC_CHECK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`endif

// ----- hdl/rsc_pkg.sv -----
// Package for the range sample conditioner: beat types, register codes, reset values.
// No dependencies; imported by the top level and the checker.
`timescale 1ns / 1ps

package rsc_pkg;

    localparam int MAX_WINDOW_DEF      = 16;
    localparam int ALPHA_FRAC_BITS_DEF = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET    = 3'd0,
        CFG_MED_EN    = 3'd1,
        CFG_MED_WIN   = 3'd2,
        CFG_EMA_EN    = 3'd3,
        CFG_EMA_ALPHA = 3'd4,
        CFG_WARN_THR  = 3'd5,
        CFG_CRIT_THR  = 3'd6,
        CFG_MAX_ERR   = 3'd7
    } t_cfg_idx;

    localparam logic [11:0] RST_OFFSET    = 12'd0;
    localparam logic        RST_MED_EN    = 1'b1;
    localparam logic [4:0]  RST_MED_WIN   = 5'd5;
    localparam logic        RST_EMA_EN    = 1'b1;
    localparam logic [8:0]  RST_EMA_ALPHA = 9'd77;
    localparam logic [15:0] RST_WARN_THR  = 16'd300;
    localparam logic [15:0] RST_CRIT_THR  = 16'd100;
    localparam logic [7:0]  RST_MAX_ERR   = 8'd10;

    typedef struct packed {
        logic [15:0] range_mm;
        logic [7:0]  status_code;
        logic        bus_error;
    } t_rsc_in;

    typedef struct packed {
        logic        reading_ok;
        logic [15:0] filtered_mm;
        logic        warning;
        logic        critical;
        logic        warning_changed;
        logic        critical_changed;
        logic [7:0]  error_run;
        logic        sensor_fault;
    } t_rsc_out;

endpackage

// ----- hdl/range_sample_conditioner.sv -----
// Path, accepting edge to o_valid: invalid reading S_CALC, S_PUSH; valid reading S_CALC,
//   S_WRITE with median on, then S_CAND, S_LOAD, S_SCAN per rank candidate once the window
//   holds W, then S_MUL1, with smoothing S_MUL2 and S_SUM, then S_FLAG, S_PUSH. One reading
//   at a time: o_stall stays high until S_PUSH loads the output, which waits on i_stall.
// Reset (synchronous, active low) clears config to defaults, filter state, flags,
//   error count, window fill and head; window memory contents are not cleared.
`timescale 1ns / 1ps

module range_sample_conditioner
    import rsc_pkg::*;
#(
    parameter int MAX_WINDOW      = MAX_WINDOW_DEF,
    parameter int ALPHA_FRAC_BITS = ALPHA_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_rsc_in               i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_rsc_out              o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int F       = ALPHA_FRAC_BITS;
    localparam int AW      = $clog2(MAX_WINDOW);
    localparam int PW      = $clog2(MAX_WINDOW + 1);
    localparam int SW      = 16 + F;
    localparam int AL_W    = F + 1;
    localparam int PR_W    = AL_W + SW;
    localparam int ACC_W   = PR_W + 1;
    localparam int ONE_INT = 1 << F;
    localparam logic [AL_W-1:0]  ONE_A    = {1'b1, {F{1'b0}}};
    localparam logic [ACC_W-1:0] HALF_ACC = {{(ACC_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_CALC, S_WRITE, S_CAND, S_LOAD, S_SCAN,
        S_MUL1, S_MUL2, S_SUM, S_FLAG, S_PUSH
    } t_state;

    // configuration
    logic [11:0] r_cfg_offset;
    logic        r_cfg_med_en;
    logic [4:0]  r_cfg_med_win;
    logic        r_cfg_ema_en;
    logic [8:0]  r_cfg_alpha;
    logic [15:0] r_cfg_warn;
    logic [15:0] r_cfg_crit;
    logic [7:0]  r_cfg_max_err;

    // control and filter state
    t_state          r_state;
    logic [PW-1:0]   r_fill;
    logic [AW-1:0]   r_head;
    logic [SW-1:0]   r_smooth;
    logic            r_warn;
    logic            r_crit;
    logic [7:0]      r_err_cnt;
    logic            r_ok;
    logic            r_wchg;
    logic            r_cchg;
    logic            r_out_valid;
    t_rsc_out        r_out;

    // working registers
    t_rsc_in         r_in;
    logic [15:0]     r_x;
    logic [15:0]     r_cand;
    logic [PW-1:0]   r_cand_p;
    logic [PW-1:0]   r_scan_p;
    logic [PW-1:0]   r_cmp_p;
    logic [PW-1:0]   r_rank;
    logic [PR_W-1:0] r_prod;
    logic [ACC_W-1:0] r_acc;

    // window memory
    logic [15:0]     r_win_mem [MAX_WINDOW];
    logic [15:0]     r_rd_data;
    logic [AW-1:0]   rd_addr;
    logic [PW-1:0]   rd_p;
    logic            win_we;

    logic [PW-1:0]   win_eff;
    logic [PW-1:0]   med_rank;
    logic [AL_W-1:0] a_eff;
    logic [17:0]     sum18;
    logic [15:0]     x_clamped;
    logic [PW-1:0]   n_fill;
    logic            is_less;
    logic [PW-1:0]   n_rank;
    logic [AL_W-1:0] mul_a;
    logic [SW-1:0]   mul_b;
    logic [PR_W-1:0] mul_p;
    logic [ACC_W-1:0] acc_sum;
    logic [SW-1:0]   n_smooth;
    logic            n_warn;
    logic            n_crit;

    // ring slot of the p-th most recent sample (p = 0 is newest)
    function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] head,
                                                input logic [PW-1:0] p);
        logic [AW+1:0] t;
        t = (AW+2)'(head) + (AW+2)'(MAX_WINDOW - 1) - (AW+2)'(p);
        if (t >= (AW+2)'(MAX_WINDOW)) begin
            t = t - (AW+2)'(MAX_WINDOW);
        end
        return t[AW-1:0];
    endfunction

    always_comb begin
        if (r_cfg_med_win == '0) begin
            win_eff = PW'(1);
        end else if (32'(r_cfg_med_win) > MAX_WINDOW) begin
            win_eff = PW'(MAX_WINDOW);
        end else begin
            win_eff = PW'(r_cfg_med_win);
        end
    end

    assign med_rank = win_eff >> 1;

    always_comb begin
        if (32'(r_cfg_alpha) > ONE_INT) begin
            a_eff = ONE_A;
        end else begin
            a_eff = AL_W'(r_cfg_alpha);
        end
    end

    // offset add and clamp to 0..65535
    assign sum18 = {2'b00, r_in.range_mm} + {{6{r_cfg_offset[11]}}, r_cfg_offset};
    always_comb begin
        if (sum18[17]) begin
            x_clamped = 16'd0;
        end else if (sum18[16]) begin
            x_clamped = 16'hFFFF;
        end else begin
            x_clamped = sum18[15:0];
        end
    end

    assign n_fill = (r_fill >= win_eff) ? win_eff : r_fill + PW'(1);

    // rank with ties broken by age so every entry gets a distinct rank
    assign is_less = (r_rd_data < r_cand) || ((r_rd_data == r_cand) && (r_cmp_p < r_cand_p));
    assign n_rank  = r_rank + PW'(is_less);

    always_comb begin
        if (r_state == S_CAND) begin
            rd_p = r_cand_p;
        end else if (r_scan_p < win_eff) begin
            rd_p = r_scan_p;
        end else begin
            rd_p = '0;
        end
    end
    assign rd_addr = ring_slot(r_head, rd_p);
    assign win_we  = (r_state == S_WRITE);

    always_ff @(posedge i_clk) begin
        if (win_we) begin
            r_win_mem[r_head] <= r_x;
        end
        r_rd_data <= r_win_mem[rd_addr];
    end

    // shared multiplier: alpha * x, then (1 - alpha) * s
    assign mul_a    = (r_state == S_MUL1) ? a_eff : ONE_A - a_eff;
    assign mul_b    = (r_state == S_MUL1) ? SW'(r_x) : r_smooth;
    assign mul_p    = PR_W'(mul_a) * PR_W'(mul_b);
    assign acc_sum  = r_acc + ACC_W'(r_prod);
    assign n_smooth = SW'(acc_sum >> F);

    assign n_warn = r_smooth < {r_cfg_warn, {F{1'b0}}};
    assign n_crit = r_smooth < {r_cfg_crit, {F{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_offset  <= RST_OFFSET;
            r_cfg_med_en  <= RST_MED_EN;
            r_cfg_med_win <= RST_MED_WIN;
            r_cfg_ema_en  <= RST_EMA_EN;
            r_cfg_alpha   <= RST_EMA_ALPHA;
            r_cfg_warn    <= RST_WARN_THR;
            r_cfg_crit    <= RST_CRIT_THR;
            r_cfg_max_err <= RST_MAX_ERR;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_OFFSET:    r_cfg_offset  <= i_cfg_data[11:0];
                CFG_MED_EN:    r_cfg_med_en  <= i_cfg_data[0];
                CFG_MED_WIN:   r_cfg_med_win <= i_cfg_data[4:0];
                CFG_EMA_EN:    r_cfg_ema_en  <= i_cfg_data[0];
                CFG_EMA_ALPHA: r_cfg_alpha   <= i_cfg_data[8:0];
                CFG_WARN_THR:  r_cfg_warn    <= i_cfg_data;
                CFG_CRIT_THR:  r_cfg_crit    <= i_cfg_data;
                CFG_MAX_ERR:   r_cfg_max_err <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_head      <= '0;
            r_smooth    <= '0;
            r_warn      <= 1'b0;
            r_crit      <= 1'b0;
            r_err_cnt   <= '0;
            r_ok        <= 1'b0;
            r_wchg      <= 1'b0;
            r_cchg      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // S_PUSH reloads the output register itself
            if (r_out_valid && !i_stall && (r_state != S_PUSH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in    <= i_item;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_wchg <= 1'b0;
                    r_cchg <= 1'b0;
                    if (r_in.bus_error || (r_in.status_code != '0)) begin
                        r_ok <= 1'b0;
                        if (r_err_cnt != 8'hFF) begin
                            r_err_cnt <= r_err_cnt + 8'd1;
                        end
                        r_state <= S_PUSH;
                    end else begin
                        r_ok      <= 1'b1;
                        r_err_cnt <= '0;
                        r_x       <= x_clamped;
                        r_state   <= r_cfg_med_en ? S_WRITE : S_MUL1;
                    end
                end
                S_WRITE: begin
                    r_head   <= (r_head == AW'(MAX_WINDOW - 1)) ? '0 : r_head + AW'(1);
                    r_fill   <= n_fill;
                    r_cand_p <= '0;
                    // pass-through until the window has filled
                    r_state  <= (n_fill < win_eff) ? S_MUL1 : S_CAND;
                end
                S_CAND: begin
                    r_scan_p <= '0;
                    r_state  <= S_LOAD;
                end
                S_LOAD: begin
                    r_cand   <= r_rd_data;
                    r_scan_p <= PW'(1);
                    r_cmp_p  <= '0;
                    r_rank   <= '0;
                    r_state  <= S_SCAN;
                end
                S_SCAN: begin
                    r_rank   <= n_rank;
                    r_scan_p <= r_scan_p + PW'(1);
                    r_cmp_p  <= r_cmp_p + PW'(1);
                    if (r_cmp_p == win_eff - PW'(1)) begin
                        if (n_rank == med_rank) begin
                            r_x     <= r_cand;
                            r_state <= S_MUL1;
                        end else begin
                            r_cand_p <= r_cand_p + PW'(1);
                            r_state  <= S_CAND;
                        end
                    end
                end
                S_MUL1: begin
                    if (r_cfg_ema_en) begin
                        r_prod  <= mul_p;
                        r_state <= S_MUL2;
                    end else begin
                        r_smooth <= {r_x, {F{1'b0}}};
                        r_state  <= S_FLAG;
                    end
                end
                S_MUL2: begin
                    r_acc   <= ACC_W'(r_prod << F) + HALF_ACC;
                    r_prod  <= mul_p;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_smooth <= n_smooth;
                    r_state  <= S_FLAG;
                end
                S_FLAG: begin
                    r_wchg  <= n_warn != r_warn;
                    r_cchg  <= n_crit != r_crit;
                    r_warn  <= n_warn;
                    r_crit  <= n_crit;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out.reading_ok       <= r_ok;
                        r_out.filtered_mm      <= r_smooth[SW-1:F];
                        r_out.warning          <= r_warn;
                        r_out.critical         <= r_crit;
                        r_out.warning_changed  <= r_wchg;
                        r_out.critical_changed <= r_cchg;
                        r_out.error_run        <= r_err_cnt;
                        r_out.sensor_fault     <= r_err_cnt >= r_cfg_max_err;
                        r_out_valid            <= 1'b1;
                        r_state                <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- hdl/rsc_checker.sv -----
// Port-level checker for range_sample_conditioner, bound to the top level.
// Depends on rsc_pkg and range_sample_conditioner_defines.svh.
`timescale 1ns / 1ps
`include "range_sample_conditioner_defines.svh"

module rsc_checker
    import rsc_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_valid,
    input logic     o_stall,
    input logic     o_valid,
    input logic     i_stall,
    input t_rsc_out o_result
);

    // one reading in flight: busy right after an input beat
    `RSC_CHECK(a_busy_after_accept, (i_valid && !o_stall) |=> o_stall, "accepted beat while busy")

    `RSC_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> o_valid, "output beat dropped")

    // error run is zero exactly when the reading was good
    `RSC_CHECK(a_ok_vs_run, o_valid |-> (o_result.reading_ok == (o_result.error_run == 8'd0)), "reading_ok and error_run disagree")

    `RSC_CHECK(a_no_chg_on_bad, (o_valid && !o_result.reading_ok) |-> (!o_result.warning_changed && !o_result.critical_changed), "flag change on invalid reading")

endmodule

bind range_sample_conditioner rsc_checker u_rsc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_result (o_result)
);
